FILE: src/pdd_pkg.sv
// Shared types and constants of the pulse phase detector and decoder.
`timescale 1ns / 1ps

package pdd_pkg;

	// Fixed field widths
	localparam int KIND_W  = 2;
	localparam int BIN_W   = 7;
	localparam int COUNT_W = 16;
	localparam int QUAL_W  = 21;
	localparam int SYM_W   = 2;
	localparam int WL_W    = 5;
	localparam int HC_W    = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 21;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_HIST   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EVAL   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DECODE = 2'd2;

	// Result kinds
	localparam logic RES_PHASE  = 1'b0;
	localparam logic RES_SYMBOL = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_CEILING = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOCK_MARGIN   = 1'd1;

	// Register reset values
	localparam logic [COUNT_W-1:0] CEILING_RST = 16'd300;
	localparam logic [QUAL_W-1:0]  MARGIN_RST  = 21'd30;

	// Correlation shape: weight 2 on WIN_HI bins, weight 1 up to WIN_ALL bins
	localparam int WIN_HI  = 10;
	localparam int WIN_ALL = 20;

	// Decode window
	localparam int WINDOW_LEN  = 22;
	localparam int HALF_MARK   = 11;
	localparam int HALF_THRESH = 5;
	localparam int NEAR_AFTER  = 10;
	localparam int NEAR_BEFORE = 1;

	// Phase offset that is never accepted as lock
	localparam int REJECT_POS = 53;

	// First half high gives the upper symbol bit
	localparam logic [SYM_W-1:0] SYM_FIRST_HIGH = 2'd2;
	localparam logic [SYM_W-1:0] SYM_FIRST_LOW  = 2'd0;

	// Symbol event from the decoder
	typedef struct packed {
		logic             valid;
		logic [SYM_W-1:0] symbol;
	} pdd_sym_t;

endpackage

FILE: src/pulse_phase_detector_decoder.sv
// Top level of the pulse phase detector and pulse decoder.
//
//  channel  dir  handshake              payload
//  s_axis   in   tvalid/tready          tuser kind, tdata bin_pos, sample_bit
//  m_axis   out  tvalid/tready          tuser result_kind, tdata locked..symbol
//  cfg      in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One request at a time. A histogram sample is read, then its bin count
// is written back. A decode sample steps the decoder when taken and, when it
// closes a symbol, moves on to emit the symbol. An evaluate request lasts
// through the correlation walk: BINS + 19 reads for the peak, 20 for the
// noise, one read per cycle on the count memory port.
// Reset clears the count store at once through per-bin valid bits.
// A result waiting in the output register holds only the next result; a new
// request is still taken while it waits. Config is always ready.
`timescale 1ns / 1ps

module pulse_phase_detector_decoder #(
	parameter int BINS = 100
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [6:0] bin_pos, [7] sample_bit
	input  logic [7:0]                     s_axis_tdata,
	// [1:0] kind
	input  logic [1:0]                     s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [0] locked, [7:1] phase_index, [28:8] quality, [30:29] symbol, [31] zero
	output logic [31:0]                    m_axis_tdata,
	// [0] result_kind
	output logic [0:0]                     m_axis_tuser,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pdd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pdd_pkg::*;

	localparam int IDX_W      = $clog2(BINS);
	localparam int WRAP_STEPS = (128 + BINS - 1) / BINS - 1;

	localparam logic [1:0] S_IDLE    = 2'd0;
	localparam logic [1:0] S_HIST_WR = 2'd1;
	localparam logic [1:0] S_EVAL    = 2'd2;
	localparam logic [1:0] S_EMIT    = 2'd3;

	logic [1:0]         state_q;
	logic               in_acc;
	logic [KIND_W-1:0]  kind;
	logic [BIN_W-1:0]   bin_raw;
	logic [IDX_W-1:0]   bin;
	logic               sample_bit;

	logic [COUNT_W-1:0] ceiling_q;
	logic [QUAL_W-1:0]  margin_q;
	logic [IDX_W-1:0]   last_bin_q;
	logic [IDX_W-1:0]   found_phase_q;
	logic [IDX_W-1:0]   hist_bin_q;
	logic               hist_bit_q;

	logic               mem_rd_en;
	logic [IDX_W-1:0]   mem_rd_addr;
	logic [COUNT_W-1:0] mem_rd_data;
	logic               mem_wr_en;
	logic [COUNT_W-1:0] count_new;

	logic               corr_start;
	logic               corr_rd_en;
	logic [IDX_W-1:0]   corr_rd_addr;
	logic               corr_done;
	logic [IDX_W-1:0]   corr_phase;
	logic [QUAL_W-1:0]  corr_quality;
	logic [IDX_W:0]     lock_dist;
	logic               corr_locked;

	pdd_sym_t           sym;

	logic               res_kind_q;
	logic               res_locked_q;
	logic [IDX_W-1:0]   res_phase_q;
	logic [QUAL_W-1:0]  res_quality_q;
	logic [SYM_W-1:0]   res_symbol_q;

	logic               out_valid_q;
	logic               out_kind_q;
	logic               out_locked_q;
	logic [BIN_W-1:0]   out_phase_q;
	logic [QUAL_W-1:0]  out_quality_q;
	logic [SYM_W-1:0]   out_symbol_q;
	logic               out_free;

	// Input unpack and bin reduction
	assign kind       = s_axis_tuser;
	assign bin_raw    = s_axis_tdata[6:0];
	assign sample_bit = s_axis_tdata[7];

	always_comb begin
		logic [BIN_W-1:0] v;
		v = bin_raw;
		for (int k = 0; k < WRAP_STEPS; k++) begin
			if (v >= BIN_W'(BINS)) begin
				v = v - BIN_W'(BINS);
			end
		end
		bin = v[IDX_W-1:0];
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign corr_start    = in_acc && (kind == KIND_EVAL);

	// Config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q <= CEILING_RST;
			margin_q  <= MARGIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COUNT_CEILING: ceiling_q <= cfg_data[COUNT_W-1:0];
				REG_LOCK_MARGIN:   margin_q  <= cfg_data[QUAL_W-1:0];
				default: ;
			endcase
		end
	end

	// Count memory access: histogram read-modify-write or correlation walk
	assign mem_rd_en   = corr_rd_en || (in_acc && (kind == KIND_HIST));
	assign mem_rd_addr = corr_rd_en ? corr_rd_addr : bin;
	assign mem_wr_en   = (state_q == S_HIST_WR);

	always_comb begin
		count_new = mem_rd_data;
		if (hist_bit_q) begin
			if (mem_rd_data < ceiling_q) begin
				count_new = mem_rd_data + 1'b1;
			end
		end else if (mem_rd_data != '0) begin
			count_new = mem_rd_data - 1'b1;
		end
	end

	pdd_count_mem #(
		.DEPTH (BINS),
		.IDX_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (hist_bin_q),
		.wr_data (count_new)
	);

	pdd_corr #(
		.BINS  (BINS),
		.IDX_W (IDX_W)
	) u_corr (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (corr_start),
		.rd_en   (corr_rd_en),
		.rd_addr (corr_rd_addr),
		.rd_data (mem_rd_data),
		.done    (corr_done),
		.phase   (corr_phase),
		.quality (corr_quality)
	);

	pdd_pulse_dec #(
		.BINS  (BINS),
		.IDX_W (IDX_W)
	) u_dec (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (in_acc && (kind == KIND_DECODE)),
		.bin        (bin),
		.sample_bit (sample_bit),
		.phase      (found_phase_q),
		.sym        (sym)
	);

	// Lock: enough margin and the last bin not at the rejected offset
	always_comb begin
		lock_dist = (last_bin_q >= corr_phase) ?
			((IDX_W+1)'(last_bin_q) - (IDX_W+1)'(corr_phase)) :
			((IDX_W+1)'(last_bin_q) + (IDX_W+1)'(BINS) - (IDX_W+1)'(corr_phase));
		corr_locked = (corr_quality >= margin_q) &&
			(BIN_W'(lock_dist) != BIN_W'(REJECT_POS));
	end

	assign out_free = !out_valid_q || m_axis_tready;

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_acc && (kind == KIND_HIST)) begin
			hist_bin_q <= bin;
			hist_bit_q <= sample_bit;
		end
		if (corr_done) begin
			res_kind_q    <= RES_PHASE;
			res_locked_q  <= corr_locked;
			res_phase_q   <= corr_phase;
			res_quality_q <= corr_quality;
			res_symbol_q  <= '0;
		end else if (sym.valid) begin
			res_kind_q    <= RES_SYMBOL;
			res_locked_q  <= 1'b0;
			res_phase_q   <= '0;
			res_quality_q <= '0;
			res_symbol_q  <= sym.symbol;
		end
		if ((state_q == S_EMIT) && out_free) begin
			out_kind_q    <= res_kind_q;
			out_locked_q  <= res_locked_q;
			out_phase_q   <= BIN_W'(res_phase_q);
			out_quality_q <= res_quality_q;
			out_symbol_q  <= res_symbol_q;
		end
	end

	// Control: sequencer, scalar state, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			last_bin_q    <= '0;
			found_phase_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			// a new result replaces the one taken downstream in the same cycle
			if ((state_q == S_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (kind)
							KIND_HIST: begin
								last_bin_q <= bin;
								state_q    <= S_HIST_WR;
							end
							KIND_EVAL: begin
								state_q <= S_EVAL;
							end
							KIND_DECODE: begin
								last_bin_q <= bin;
								if (sym.valid) begin
									state_q <= S_EMIT;
								end
							end
							default: ;
						endcase
					end
				end
				S_HIST_WR: begin
					state_q <= S_IDLE;
				end
				S_EVAL: begin
					if (corr_done) begin
						found_phase_q <= corr_phase;
						state_q       <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output pack
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = {1'b0, out_symbol_q, out_quality_q, out_phase_q, out_locked_q};

	// Checks
	a_done_in_eval: assert property (@(posedge clk) disable iff (!arst_n)
		corr_done |-> (state_q == S_EVAL))
		else $error("correlation finished outside evaluation");

	a_walk_in_eval: assert property (@(posedge clk) disable iff (!arst_n)
		corr_rd_en |-> (state_q == S_EVAL) && !mem_wr_en)
		else $error("correlation read outside evaluation");

	a_hist_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (kind == KIND_HIST)) |=> mem_wr_en && (hist_bin_q == $past(bin)))
		else $error("histogram request not written back");

	a_emit_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) && !out_free |=> (state_q == S_EMIT) && out_valid_q)
		else $error("pending result dropped");

endmodule

FILE: src/pdd_count_mem.sv
// Bin count memory: one write port, one registered read port, per-entry valid bits.
`timescale 1ns / 1ps

module pdd_count_mem #(
	parameter int DEPTH = 100,
	parameter int IDX_W = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [IDX_W-1:0]            rd_addr,
	output logic [pdd_pkg::COUNT_W-1:0] rd_data,
	input  logic                        wr_en,
	input  logic [IDX_W-1:0]            wr_addr,
	input  logic [pdd_pkg::COUNT_W-1:0] wr_data
);
	import pdd_pkg::*;

	logic [COUNT_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]   vld_q;
	logic [COUNT_W-1:0] rd_data_q;
	logic               rd_vld_q;

	// Storage array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Valid bits: an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

FILE: src/pdd_corr.sv
// Correlation walk over the count memory: peak search, then noise sum.
`timescale 1ns / 1ps

module pdd_corr #(
	parameter int BINS  = 100,
	parameter int IDX_W = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        rd_en,
	output logic [IDX_W-1:0]            rd_addr,
	input  logic [pdd_pkg::COUNT_W-1:0] rd_data,
	output logic                        done,
	output logic [IDX_W-1:0]            phase,
	output logic [pdd_pkg::QUAL_W-1:0]  quality
);
	import pdd_pkg::*;

	localparam int PEAK_LEN  = BINS + WIN_ALL - 1;
	localparam int NOISE_LEN = WIN_ALL;
	localparam int CNT_W     = $clog2(BINS + WIN_ALL);
	localparam int SUM_W     = $clog2(2 * BINS);

	localparam logic [1:0] C_IDLE  = 2'd0;
	localparam logic [1:0] C_PEAK  = 2'd1;
	localparam logic [1:0] C_NOISE = 2'd2;
	localparam logic [1:0] C_DONE  = 2'd3;

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   j_q;
	logic [CNT_W-1:0]   base_q;
	logic               issue;
	logic [SUM_W-1:0]   addr_sum;
	logic               rd_vld_s1;
	logic               peak_s1;
	logic [CNT_W-1:0]   j_s1;
	logic [QUAL_W-1:0]  corr_q;
	logic [QUAL_W-1:0]  corr_next;
	logic [COUNT_W-1:0] hist_q [WIN_ALL];
	logic               cmp_vld_s2;
	logic [IDX_W-1:0]   cmp_idx_s2;
	logic [QUAL_W-1:0]  best_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [QUAL_W-1:0]  quality_q;

	// Read issue and circular address
	always_comb begin
		issue = ((state_q == C_PEAK) && (j_q < CNT_W'(PEAK_LEN))) ||
			((state_q == C_NOISE) && (j_q < CNT_W'(NOISE_LEN)));
		addr_sum = SUM_W'(base_q) + SUM_W'(j_q);
		if (addr_sum >= SUM_W'(BINS)) begin
			addr_sum = addr_sum - SUM_W'(BINS);
		end
	end

	assign rd_en   = issue;
	assign rd_addr = addr_sum[IDX_W-1:0];

	// Accumulate: direct sum over the first window, sliding update after it
	always_comb begin
		if (j_s1 < CNT_W'(WIN_ALL)) begin
			corr_next = ((j_s1 == '0) ? '0 : corr_q) +
				((j_s1 < CNT_W'(WIN_HI)) ? QUAL_W'({rd_data, 1'b0}) : QUAL_W'(rd_data));
		end else begin
			corr_next = corr_q + QUAL_W'(rd_data) + QUAL_W'(hist_q[WIN_HI-1]) -
				QUAL_W'({hist_q[WIN_ALL-1], 1'b0});
		end
	end

	// Count history for the sliding update
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			hist_q[0] <= rd_data;
			for (int k = 1; k < WIN_ALL; k++) begin
				hist_q[k] <= hist_q[k-1];
			end
			corr_q <= corr_next;
		end
		j_s1       <= j_q;
		peak_s1    <= (state_q == C_PEAK);
		cmp_idx_s2 <= IDX_W'(j_s1 - CNT_W'(WIN_ALL - 1));
	end

	// Sequencer, peak tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= C_IDLE;
			j_q        <= '0;
			base_q     <= '0;
			rd_vld_s1  <= 1'b0;
			cmp_vld_s2 <= 1'b0;
			best_q     <= '0;
			best_idx_q <= '0;
			quality_q  <= '0;
		end else begin
			rd_vld_s1  <= issue;
			cmp_vld_s2 <= rd_vld_s1 && peak_s1 && (j_s1 >= CNT_W'(WIN_ALL - 1));
			if (issue) begin
				j_q <= j_q + 1'b1;
			end
			// first maximum wins
			if (cmp_vld_s2 && (corr_q > best_q)) begin
				best_q     <= corr_q;
				best_idx_q <= cmp_idx_s2;
			end
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						j_q        <= '0;
						base_q     <= '0;
						best_q     <= '0;
						best_idx_q <= '0;
						state_q    <= C_PEAK;
					end
				end
				C_PEAK: begin
					if ((j_q == CNT_W'(PEAK_LEN)) && !rd_vld_s1 && !cmp_vld_s2) begin
						j_q     <= '0;
						base_q  <= CNT_W'(best_idx_q) + CNT_W'(WIN_ALL);
						state_q <= C_NOISE;
					end
				end
				C_NOISE: begin
					if ((j_q == CNT_W'(NOISE_LEN)) && !rd_vld_s1) begin
						quality_q <= best_q - corr_q;
						state_q   <= C_DONE;
					end
				end
				C_DONE: begin
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign done    = (state_q == C_DONE);
	assign phase   = best_idx_q;
	assign quality = quality_q;

endmodule

FILE: src/pdd_pulse_dec.sv
// Pulse decoder: window near the phase, high counts per half, symbol out.
`timescale 1ns / 1ps

module pdd_pulse_dec #(
	parameter int BINS  = 100,
	parameter int IDX_W = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [IDX_W-1:0]    bin,
	input  logic                sample_bit,
	input  logic [IDX_W-1:0]    phase,
	output pdd_pkg::pdd_sym_t   sym
);
	import pdd_pkg::*;

	logic [WL_W-1:0]  wl_q, wl_a, wl_n;
	logic [HC_W-1:0]  hc_q, hc_n;
	logic [SYM_W-1:0] ps_q, ps_n;
	logic [IDX_W:0]   fwd, rev;
	logic             emit;

	// Circular distance of the bin after and before the phase
	always_comb begin
		fwd = (bin >= phase) ? ((IDX_W+1)'(bin) - (IDX_W+1)'(phase)) :
			((IDX_W+1)'(bin) + (IDX_W+1)'(BINS) - (IDX_W+1)'(phase));
		rev = (phase >= bin) ? ((IDX_W+1)'(phase) - (IDX_W+1)'(bin)) :
			((IDX_W+1)'(phase) + (IDX_W+1)'(BINS) - (IDX_W+1)'(bin));
	end

	// Window step
	always_comb begin
		wl_a = wl_q;
		if ((wl_q == '0) && ((fwd <= (IDX_W+1)'(NEAR_AFTER)) ||
				(rev <= (IDX_W+1)'(NEAR_BEFORE)))) begin
			wl_a = WL_W'(WINDOW_LEN);
		end
		wl_n = wl_a;
		hc_n = hc_q;
		ps_n = ps_q;
		emit = 1'b0;
		if (wl_a != '0) begin
			wl_n = wl_a - 1'b1;
			hc_n = hc_q + HC_W'(sample_bit);
			if (wl_n == WL_W'(HALF_MARK)) begin
				ps_n = (hc_n > HC_W'(HALF_THRESH)) ? SYM_FIRST_HIGH : SYM_FIRST_LOW;
				hc_n = '0;
			end else if (wl_n == '0) begin
				ps_n = ps_q + SYM_W'(hc_n > HC_W'(HALF_THRESH));
				hc_n = '0;
				emit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= '0;
			hc_q <= '0;
			ps_q <= '0;
		end else if (step) begin
			wl_q <= wl_n;
			hc_q <= hc_n;
			ps_q <= ps_n;
		end
	end

	assign sym.valid  = step && emit;
	assign sym.symbol = ps_n;

endmodule

FILE: tb/tb_pulse_phase_detector_decoder.sv
// Self-checking testbench of the pulse phase detector and decoder, with its scoreboard.
`timescale 1ns / 1ps

module tb_pulse_phase_detector_decoder;
	import pdd_pkg::*;

	localparam int NUM_BINS      = 100;
	localparam int SETTLE_CYCLES = 3 * NUM_BINS;
	localparam int HOLD_CYCLES   = 600;
	localparam int LIMIT_CYCLES  = 1_000_000;
	localparam int PHASE_QUOTA   = 400;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	// One expected result, field by field
	typedef struct {
		logic              result_kind;
		logic              locked;
		logic [BIN_W-1:0]  phase_index;
		logic [QUAL_W-1:0] quality;
		logic [SYM_W-1:0]  symbol;
	} pulse_report_t;

	// Tracks histogram, phase and decode window; holds the expected reports
	class phase_decode_scoreboard;
		logic [COUNT_W-1:0] bin_tally[NUM_BINS];
		logic [COUNT_W-1:0] ceiling;
		logic [QUAL_W-1:0]  margin;
		int last_bin, found_phase, window_left, high_count;
		logic [SYM_W-1:0] partial_symbol;
		pulse_report_t pending_reports[$];
		int errors;

		function new();
			foreach (bin_tally[i]) bin_tally[i] = '0;
			ceiling = CEILING_RST;
			margin = MARGIN_RST;
			last_bin = 0;
			found_phase = 0;
			window_left = 0;
			high_count = 0;
			partial_symbol = '0;
			errors = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			if (idx == REG_COUNT_CEILING) begin
				ceiling = value[COUNT_W-1:0];
			end else begin
				margin = value[QUAL_W-1:0];
			end
		endfunction

		function int pending();
			return pending_reports.size();
		endfunction

		// Weight 2 on the first WIN_HI bins, weight 1 on the rest, circular
		function int window_sum(int start);
			int total;
			total = 0;
			for (int k = 0; k < WIN_ALL; k++)
				total += (k < WIN_HI) ? 2 * bin_tally[(start + k) % NUM_BINS]
					: bin_tally[(start + k) % NUM_BINS];
			return total;
		endfunction

		function void note_request(logic [KIND_W-1:0] kind, logic [BIN_W-1:0] raw_bin,
			logic sample_v);
			int bin, best, best_at, noise, qual, sum;
			pulse_report_t rep;
			bin = raw_bin % NUM_BINS;
			case (kind)
			KIND_HIST: begin
				last_bin = bin;
				if (sample_v) begin
					if (bin_tally[bin] < ceiling) bin_tally[bin]++;
				end else if (bin_tally[bin] > 0) begin
					bin_tally[bin]--;
				end
			end
			KIND_EVAL: begin
				// first maximum wins
				best = 0;
				best_at = 0;
				for (int b = 0; b < NUM_BINS; b++) begin
					sum = window_sum(b);
					if (sum > best) begin
						best = sum;
						best_at = b;
					end
				end
				found_phase = best_at;
				noise = window_sum((best_at + WIN_ALL) % NUM_BINS);
				qual = best - noise;
				rep.result_kind = RES_PHASE;
				rep.locked = (qual >= margin) &&
					((NUM_BINS + last_bin - found_phase) % NUM_BINS != REJECT_POS);
				rep.phase_index = BIN_W'(found_phase);
				rep.quality = QUAL_W'(qual);
				rep.symbol = '0;
				pending_reports.push_back(rep);
			end
			KIND_DECODE: begin
				last_bin = bin;
				// window opens a little before or up to NEAR_AFTER bins after the phase
				if (window_left == 0 &&
					((NUM_BINS + last_bin - found_phase) % NUM_BINS <= NEAR_AFTER ||
					(NUM_BINS + found_phase - last_bin) % NUM_BINS <= NEAR_BEFORE))
					window_left = WINDOW_LEN;
				if (window_left > 0) begin
					window_left--;
					high_count += sample_v;
					if (window_left == HALF_MARK) begin
						partial_symbol = (high_count > HALF_THRESH) ? SYM_FIRST_HIGH
							: SYM_FIRST_LOW;
						high_count = 0;
					end else if (window_left == 0) begin
						partial_symbol = partial_symbol + (high_count > HALF_THRESH);
						high_count = 0;
						rep.result_kind = RES_SYMBOL;
						rep.locked = 1'b0;
						rep.phase_index = '0;
						rep.quality = '0;
						rep.symbol = partial_symbol;
						pending_reports.push_back(rep);
					end
				end
			end
			default: begin
			end
			endcase
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [31:0] data, logic [0:0] user);
			pulse_report_t want;
			if (pending_reports.size() == 0) begin
				$error("result with nothing pending: tuser %0h tdata %0h", user, data);
				errors++;
				return;
			end
			want = pending_reports.pop_front();
			compare_field("result_kind", 32'(want.result_kind), 32'(user[0]));
			compare_field("locked", 32'(want.locked), 32'(data[0]));
			compare_field("phase_index", 32'(want.phase_index), 32'(data[7:1]));
			compare_field("quality", 32'(want.quality), 32'(data[28:8]));
			compare_field("symbol", 32'(want.symbol), 32'(data[30:29]));
			compare_field("pad", 32'd0, 32'(data[31]));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	phase_decode_scoreboard sb;
	int source_idle_pct = 0;
	int sink_idle_pct = 50;
	int requests_sent = 0;
	int holds_asked = 0;
	int pulse_bin = 30;
	int cycles = 0;

	pulse_phase_detector_decoder #(
		.BINS(NUM_BINS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Timeout
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Monitor both streams
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata, m_axis_tuser);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_request(s_axis_tuser, s_axis_tdata[6:0], s_axis_tdata[7]);
		end
	end

	// Receiver: random stalls, plus a long hold-off on request
	initial begin : sink
		int hold_left;
		int holds_served;
		hold_left = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && holds_served != holds_asked) begin
				hold_left = HOLD_CYCLES;
				holds_served++;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= arst_n && ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// Offer one request and wait for it to be taken, then maybe idle
	task automatic offer_request(input logic [KIND_W-1:0] kind, input logic [BIN_W-1:0] bin,
		input logic sample_v);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {sample_v, bin};
		do @(posedge clk); while (!s_axis_tready);
		if (kind != KIND_UNUSED) requests_sent++;
		if ($urandom_range(99) < source_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Drained, then long enough for any decode or histogram update to finish
	task automatic wait_idle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [COUNT_W-1:0] ceiling_v,
		input logic [QUAL_W-1:0] margin_v);
		cfg_valid <= 1'b1;
		cfg_index <= REG_COUNT_CEILING;
		cfg_data <= CFG_DATA_W'(ceiling_v);
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(REG_COUNT_CEILING, CFG_DATA_W'(ceiling_v));
		cfg_index <= REG_LOCK_MARGIN;
		cfg_data <= margin_v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(REG_LOCK_MARGIN, margin_v);
		cfg_valid <= 1'b0;
	endtask

	// Samples shaped like a lowered carrier at pulse_bin, with some stray bins
	task automatic hist_burst();
		int n, offset;
		if ($urandom_range(9) == 0) pulse_bin = $urandom_range(0, NUM_BINS - 1);
		n = $urandom_range(5, 25);
		repeat (n) begin
			if ($urandom_range(9) < 7) begin
				offset = $urandom_range(0, WIN_ALL - 1);
				offer_request(KIND_HIST, BIN_W'((pulse_bin + offset) % NUM_BINS),
					$urandom_range(9) < ((offset < WIN_HI) ? 8 : 5));
			end else begin
				offer_request(KIND_HIST, BIN_W'($urandom_range(0, 127)),
					$urandom_range(9) < 2);
			end
		end
	endtask

	// A full window starting near the phase; now and then cut short
	task automatic decode_run();
		int start_bin, len, first_pct, second_pct;
		start_bin = (sb.found_phase + NUM_BINS - 1 + $urandom_range(0, 11)) % NUM_BINS;
		len = ($urandom_range(9) == 0) ? $urandom_range(1, WINDOW_LEN - 1) : WINDOW_LEN;
		first_pct = $urandom_range(0, 100);
		second_pct = $urandom_range(0, 100);
		for (int i = 0; i < len; i++)
			offer_request(KIND_DECODE, BIN_W'((start_bin + i) % NUM_BINS),
				$urandom_range(99) < ((i < HALF_MARK) ? first_pct : second_pct));
	endtask

	task automatic run_phase(input int src_pct, input int snk_pct, input bit drain_mid,
		input bit hold_mid);
		int start, pick;
		source_idle_pct = src_pct;
		sink_idle_pct = snk_pct;
		start = requests_sent;
		while (requests_sent - start < PHASE_QUOTA) begin
			if (hold_mid && requests_sent - start >= 40) begin
				hold_mid = 1'b0;
				holds_asked++;
			end
			if (drain_mid && requests_sent - start >= PHASE_QUOTA / 2) begin
				drain_mid = 1'b0;
				s_axis_tvalid <= 1'b0;
				wait_drained();
			end
			pick = $urandom_range(99);
			if (pick < 30) begin
				hist_burst();
			end else if (pick < 55) begin
				offer_request(KIND_EVAL, BIN_W'($urandom_range(0, 127)),
					1'($urandom_range(0, 1)));
			end else if (pick < 85) begin
				decode_run();
			end else begin
				repeat ($urandom_range(1, 4))
					offer_request(KIND_W'($urandom_range(0, 3)),
						BIN_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, reset register values
		offer_request(KIND_EVAL, 7'd0, 1'b0);       // empty histogram
		offer_request(KIND_UNUSED, 7'd127, 1'b1);
		offer_request(KIND_UNUSED, 7'd0, 1'b0);
		offer_request(KIND_HIST, 7'd127, 1'b1);     // wraps to bin 27
		offer_request(KIND_HIST, 7'd0, 1'b0);       // count already at zero
		offer_request(KIND_HIST, 7'd99, 1'b1);
		offer_request(KIND_EVAL, 7'd127, 1'b1);     // phase lands on bin 18
		offer_request(KIND_HIST, 7'd71, 1'b0);      // 53 bins after the phase
		offer_request(KIND_EVAL, 7'd5, 1'b0);       // rejected position
		offer_request(KIND_HIST, 7'd27, 1'b1);
		offer_request(KIND_HIST, 7'd28, 1'b1);
		offer_request(KIND_EVAL, 7'd64, 1'b0);
		offer_request(KIND_DECODE, 7'd50, 1'b1);    // far from the phase, ignored
		offer_request(KIND_DECODE, 7'd18, 1'b1);    // one bin before: window opens
		offer_request(KIND_DECODE, 7'd118, 1'b0);   // wraps to bin 18
		s_axis_tvalid <= 1'b0;

		wait_idle();
		configure(16'd1, 21'd0);
		run_phase(31, 74, 1'b0, 1'b0);
		s_axis_tvalid <= 1'b0;

		wait_idle();
		configure(16'd65535, 21'd1966050);
		run_phase(74, 31, 1'b1, 1'b0);
		s_axis_tvalid <= 1'b0;

		// lowered ceiling under counts that grew in the last phase
		wait_idle();
		configure(16'd3, 21'd20);
		run_phase(0, 0, 1'b0, 1'b1);
		s_axis_tvalid <= 1'b0;

		wait_idle();
		configure(16'd40, 21'd8);
		run_phase(0, 0, 1'b0, 1'b0);
		s_axis_tvalid <= 1'b0;

		wait_idle();
		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
src/pdd_pkg.sv
src/pdd_count_mem.sv
src/pdd_corr.sv
src/pdd_pulse_dec.sv
src/pulse_phase_detector_decoder.sv
tb/tb_pulse_phase_detector_decoder.sv
